[rtl/pfa_pkg.sv]
// Shared constants, types and codes of the page fit allocator.
package pfa_pkg;

  localparam int NUM_PAGES = 32;
  localparam int ID_BITS   = 8;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int REQ_W     = 6;

  typedef logic [ID_BITS-1:0] owner_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [REQ_W-1:0]   req_t;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_KILL = 2'd1,
    CMD_FRAG = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RUNNING     = 2'd1,
    ST_NO_HOLE     = 2'd2,
    ST_NOT_RUNNING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE,
    S_DECIDE,
    S_PLACE,
    S_DONE
  } state_e;

  // Controls from the sequencer to the scanner.
  typedef struct packed {
    logic   clear;       // start of a command: clear every scan register
    logic   clear_runs;  // start of the placement pass: restart the run count
    logic   step;        // one page passes the head of the ring
    logic   close;       // close the run that reaches the last page
    logic   worst;
    owner_t id;
    req_t   req;
  } scan_ctl_t;

  // Results of the scanner.
  typedef struct packed {
    logic   present;
    logic   found;
    page_t  best_start;
    count_t runs;
    count_t freed;
  } scan_res_t;

endpackage

[rtl/pfa_if.sv]
// Valid/ready channel interfaces for commands and results.
interface pfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] prog_id;
  logic [5:0] req_pages;

  modport source (output valid, output cmd, output prog_id, output req_pages, input ready);
  modport sink   (input valid, input cmd, input prog_id, input req_pages, output ready);
endinterface

interface pfa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] start_page;
  logic [5:0] page_total;
  logic [4:0] fragments;

  modport source (output valid, output status, output start_page, output page_total,
                  output fragments, input ready);
  modport sink   (input valid, input status, input start_page, input page_total,
                  input fragments, output ready);
endinterface

[rtl/pfa_cell.sv]
// One page cell of the owner ring: holds an owner id and shifts it toward the head.
module pfa_cell import pfa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  owner_t owner_i,
  output owner_t owner_o
);

  owner_t owner_q, owner_d;

  always_comb begin
    owner_d = owner_q;
    if (shift_i) begin
      owner_d = owner_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else begin
      owner_q <= owner_d;
    end
  end

  assign owner_o = owner_q;

endmodule

[rtl/pfa_scan.sv]
// Scanner at the ring head: id search, hole selection, run count and freed count.
module pfa_scan import pfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  input  owner_t    head_i,
  input  owner_t    wb_i,
  input  page_t     pos_i,
  output scan_res_t res_o
);

  logic   present_q, present_d;
  logic   found_q, found_d;
  page_t  best_start_q, best_start_d;
  count_t best_len_q, best_len_d;
  page_t  run_start_q, run_start_d;
  count_t run_len_q, run_len_d;
  count_t runs_q, runs_d;
  logic   prev_free_q, prev_free_d;
  count_t freed_q, freed_d;

  logic take;
  logic head_free;
  logic wb_free;

  // A finished run becomes the candidate when it fits and beats the current one.
  always_comb begin
    take = 1'b0;
    if (run_len_q != '0 && 32'(run_len_q) >= 32'(ctl_i.req)) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (ctl_i.worst) begin
        take = run_len_q > best_len_q;
      end else begin
        take = run_len_q < best_len_q;
      end
    end
  end

  assign head_free = (head_i == '0);
  assign wb_free   = (wb_i == '0);

  always_comb begin
    present_d    = present_q;
    found_d      = found_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    runs_d       = runs_q;
    prev_free_d  = prev_free_q;
    freed_d      = freed_q;
    if (ctl_i.clear) begin
      present_d    = 1'b0;
      found_d      = 1'b0;
      best_start_d = '0;
      best_len_d   = '0;
      run_start_d  = '0;
      run_len_d    = '0;
      runs_d       = '0;
      prev_free_d  = 1'b0;
      freed_d      = '0;
    end else if (ctl_i.clear_runs) begin
      runs_d      = '0;
      prev_free_d = 1'b0;
    end else if (ctl_i.step) begin
      present_d = present_q | (head_i == ctl_i.id);
      // Hole tracking looks at the owners as they stood before the command.
      if (head_free) begin
        if (run_len_q == '0) begin
          run_start_d = pos_i;
        end
        run_len_d = run_len_q + count_t'(1);
      end else begin
        if (take) begin
          found_d      = 1'b1;
          best_start_d = run_start_q;
          best_len_d   = run_len_q;
        end
        run_len_d = '0;
      end
      // The run count and freed count follow the owners written back.
      if (wb_free && !prev_free_q) begin
        runs_d = runs_q + count_t'(1);
      end
      prev_free_d = wb_free;
      if (!head_free && wb_free) begin
        freed_d = freed_q + count_t'(1);
      end
    end else if (ctl_i.close) begin
      if (take) begin
        found_d      = 1'b1;
        best_start_d = run_start_q;
        best_len_d   = run_len_q;
      end
      run_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= 1'b0;
      found_q      <= 1'b0;
      best_start_q <= '0;
      best_len_q   <= '0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      runs_q       <= '0;
      prev_free_q  <= 1'b0;
      freed_q      <= '0;
    end else begin
      present_q    <= present_d;
      found_q      <= found_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      run_start_q  <= run_start_d;
      run_len_q    <= run_len_d;
      runs_q       <= runs_d;
      prev_free_q  <= prev_free_d;
      freed_q      <= freed_d;
    end
  end

  assign res_o.present    = present_q;
  assign res_o.found      = found_q;
  assign res_o.best_start = best_start_q;
  assign res_o.runs       = runs_q;
  assign res_o.freed      = freed_q;

endmodule

[rtl/page_fit_allocator.sv]
// Top level of the contiguous best-fit / worst-fit page allocator.
//
//   channel   direction  transfer when        payload
//   in_i      in         valid & ready        cmd, prog_id, req_pages
//   out_o     out        valid & ready        status, start_page, page_total, fragments
//   cfg       in         cfg_we_i             cfg_wdata_i (fit_mode)
//
// The page owners sit in a ring of NUM_PAGES cells that rotates one page per cycle past
// the scanner during a pass, so every pass brings each page past the scanner once.
// A command makes a search pass, then closes the last run and decides; a successful add
// then makes a placement pass. The result is loaded once the output register is free.
// After the load the sequencer goes back to idle before the next command can transfer.
// Reset frees all pages and selects best fit.
// A new command is taken as soon as the previous result is loaded, even while that
// result waits in the output register; a stalled output holds the next result back.
module page_fit_allocator import pfa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  pfa_in_if.sink    in_i,
  pfa_out_if.source out_o
);

  state_e state_q, state_d;
  page_t  pos_q, pos_d;
  cmd_e   cmd_q;
  owner_t id_q;
  req_t   req_q;
  page_t  start_q, start_d;
  status_e status_q, status_d;
  logic   fit_mode_q;

  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic [4:0] out_start_q;
  logic [5:0] out_total_q;
  logic [4:0] out_frag_q;

  logic      accept;
  logic      load_out;
  logic      shift;
  scan_ctl_t ctl;
  scan_res_t res;
  owner_t    owner [NUM_PAGES];
  owner_t    wb;
  logic      in_place;

  assign accept = in_i.valid && in_i.ready;

  // Owner ring: cell zero is the head, the tail takes the written-back owner.
  for (genvar k = 0; k < NUM_PAGES; k++) begin : g_cell
    if (k == NUM_PAGES - 1) begin : g_tail
      pfa_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .owner_i (wb),
        .owner_o (owner[k])
      );
    end else begin : g_body
      pfa_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .owner_i (owner[k+1]),
        .owner_o (owner[k])
      );
    end
  end

  assign in_place = (32'(pos_q) >= 32'(start_q)) &&
                    (32'(pos_q) < 32'(start_q) + 32'(req_q));

  always_comb begin
    wb = owner[0];
    unique case (state_q)
      S_SCAN: begin
        if (cmd_q == CMD_KILL && id_q != '0 && owner[0] == id_q) begin
          wb = '0;
        end
      end
      S_PLACE: begin
        if (in_place) begin
          wb = id_q;
        end
      end
      default: begin
        wb = owner[0];
      end
    endcase
  end

  pfa_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .head_i (owner[0]),
    .wb_i   (wb),
    .pos_i  (pos_q),
    .res_o  (res)
  );

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    pos_d          = pos_q;
    start_d        = start_q;
    status_d       = status_q;
    in_i.ready     = 1'b0;
    shift          = 1'b0;
    load_out       = 1'b0;
    ctl.clear      = 1'b0;
    ctl.clear_runs = 1'b0;
    ctl.step       = 1'b0;
    ctl.close      = 1'b0;
    ctl.worst      = fit_mode_q;
    ctl.id         = id_q;
    ctl.req        = req_q;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ctl.clear = 1'b1;
          pos_d     = '0;
          start_d   = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN, S_PLACE: begin
        shift    = 1'b1;
        ctl.step = 1'b1;
        if (32'(pos_q) == NUM_PAGES - 1) begin
          pos_d   = '0;
          state_d = (state_q == S_SCAN) ? S_CLOSE : S_DONE;
        end else begin
          pos_d = pos_q + page_t'(1);
        end
      end
      S_CLOSE: begin
        ctl.close = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        status_d = ST_OK;
        state_d  = S_DONE;
        unique case (cmd_q)
          CMD_ADD: begin
            if (id_q == '0 || res.present) begin
              status_d = ST_RUNNING;
            end else if (req_q == '0 || 32'(req_q) > NUM_PAGES || !res.found) begin
              status_d = ST_NO_HOLE;
            end else begin
              start_d        = res.best_start;
              ctl.clear_runs = 1'b1;
              state_d        = S_PLACE;
            end
          end
          CMD_KILL: begin
            if (res.freed == '0) begin
              status_d = ST_NOT_RUNNING;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      start_q    <= '0;
      status_q   <= ST_OK;
      fit_mode_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        fit_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Command fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(in_i.cmd);
      id_q  <= owner_t'(in_i.prog_id);
      req_q <= in_i.req_pages;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_frag_q   <= 5'(res.runs);
      out_start_q  <= '0;
      out_total_q  <= '0;
      if (status_q == ST_OK && cmd_q == CMD_ADD) begin
        out_start_q <= 5'(start_q);
        out_total_q <= 6'(req_q);
      end else if (status_q == ST_OK && cmd_q == CMD_KILL) begin
        out_total_q <= 6'(res.freed);
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.start_page = out_start_q;
  assign out_o.page_total = out_total_q;
  assign out_o.fragments  = out_frag_q;

  // The search pass ends with the ring back at its home alignment.
  a_pass_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_CLOSE) |=> (pos_q == '0))
    else $error("scan pass did not wrap the page position");

  // A granted run never extends past the last page.
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_OK) |->
      (32'(out_o.start_page) + 32'(out_o.page_total) <= NUM_PAGES))
    else $error("result run exceeds the page range");

  // Free runs are separated by owned pages, so at most half the pages start one.
  a_frag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.fragments) <= (NUM_PAGES + 1) / 2))
    else $error("fragment count above its bound");

  // No command is taken while the ring is rotating.
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_PLACE) |-> !in_i.ready)
    else $error("command taken during a pass");

endmodule

[tb/sv/pfa_outcome_checker.sv]
// Checker that predicts every allocator reply and compares it with the reply channel.
module pfa_outcome_checker import pfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  pfa_in_if    cmd_ch,
  pfa_out_if   res_ch,
  output int   mismatch_cnt_o,
  output int   owed_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e    status;
    page_t      start_page;
    count_t     page_total;
    logic [4:0] fragments;
  } outcome_t;

  owner_t   owner_map [NUM_PAGES];
  logic     worst_fit;
  outcome_t owed_q [$];
  int       mismatches;

  function automatic int free_runs();
    int runs;
    bit prev_free;
    runs = 0;
    prev_free = 1'b0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (owner_map[p] == '0 && !prev_free) runs++;
      prev_free = (owner_map[p] == '0);
    end
    return runs;
  endfunction

  // Updates the page map for one command and returns the reply it owes.
  function automatic outcome_t apply_command(cmd_e op, owner_t id, req_t req);
    outcome_t o;
    bit       present;
    bit       found;
    bit       is_free;
    int       run_start;
    int       run_len;
    int       pick_start;
    int       pick_len;
    int       freed;
    o = '0;
    case (op)
      CMD_ADD: begin
        // The free marker itself always counts as a running program.
        present = (id == '0);
        for (int p = 0; p < NUM_PAGES; p++) begin
          if (owner_map[p] == id) present = 1'b1;
        end
        found = 1'b0;
        pick_start = 0;
        pick_len = 0;
        run_start = 0;
        run_len = 0;
        if (!present && req != '0 && req <= NUM_PAGES) begin
          // One position past the last page closes a run that reaches the end.
          for (int p = 0; p <= NUM_PAGES; p++) begin
            is_free = (p < NUM_PAGES) && (owner_map[p] == '0);
            if (is_free) begin
              if (run_len == 0) run_start = p;
              run_len++;
            end else begin
              if (run_len >= req && run_len > 0) begin
                if (!found || (worst_fit ? run_len > pick_len : run_len < pick_len)) begin
                  found = 1'b1;
                  pick_start = run_start;
                  pick_len = run_len;
                end
              end
              run_len = 0;
            end
          end
        end
        if (present) begin
          o.status = ST_RUNNING;
        end else if (!found) begin
          o.status = ST_NO_HOLE;
        end else begin
          for (int k = 0; k < req; k++) owner_map[pick_start + k] = id;
          o.status = ST_OK;
          o.start_page = page_t'(pick_start);
          o.page_total = count_t'(req);
        end
      end
      CMD_KILL: begin
        freed = 0;
        if (id != '0) begin
          for (int p = 0; p < NUM_PAGES; p++) begin
            if (owner_map[p] == id) begin
              owner_map[p] = '0;
              freed++;
            end
          end
        end
        if (freed == 0) begin
          o.status = ST_NOT_RUNNING;
        end else begin
          o.status = ST_OK;
          o.page_total = count_t'(freed);
        end
      end
      default: o.status = ST_OK;
    endcase
    o.fragments = 5'(free_runs());
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      foreach (owner_map[p]) owner_map[p] = '0;
      worst_fit = 1'b0;
      owed_q.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      owed_cnt_o <= 0;
    end else begin
      if (cfg_we_i) worst_fit = cfg_wdata_i;
      // Replies are matched before new commands are queued; a command never answers itself
      // in the cycle of its own transfer.
      if (res_ch.valid && res_ch.ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply with none owed: status %0d start %0d total %0d frags %0d",
                     $realtime, res_ch.status, res_ch.start_page, res_ch.page_total,
                     res_ch.fragments);
        end else begin
          want = owed_q.pop_front();
          if (res_ch.status !== want.status || res_ch.start_page !== want.start_page ||
              res_ch.page_total !== want.page_total || res_ch.fragments !== want.fragments)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: reply mismatch: expected status %0d start %0d total %0d frags %0d,",
                       $realtime, want.status, want.start_page, want.page_total,
                       want.fragments,
                       " got status %0d start %0d total %0d frags %0d",
                       res_ch.status, res_ch.start_page, res_ch.page_total,
                       res_ch.fragments);
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        owed_q.push_back(apply_command(cmd_e'(cmd_ch.cmd), cmd_ch.prog_id, cmd_ch.req_pages));
      mismatch_cnt_o <= mismatches;
      owed_cnt_o <= owed_q.size();
    end
  end

endmodule

[tb/sv/page_fit_allocator_tb.sv]
// Top of the allocator testbench: clock, reset, command stimulus and the verdict.
module page_fit_allocator_tb import pfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  int send_idle_pct = 6;
  int rcv_idle_pct = 61;
  int live_ids [$];
  int mismatch_cnt;
  int owed_cnt;

  pfa_in_if  cmd_ch ();
  pfa_out_if res_ch ();

  page_fit_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_ch),
    .out_o       (res_ch)
  );

  pfa_outcome_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .cmd_ch         (cmd_ch),
    .res_ch         (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .owed_cnt_o     (owed_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The reply side stalls at random, one decision per clock.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Valid stays high from one transfer to the next unless a gap is rolled.
  task automatic send_cmd(input cmd_e op, input int id, input int pages);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= op;
    cmd_ch.prog_id   <= id[7:0];
    cmd_ch.req_pages <= pages[5:0];
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  task automatic drain_replies();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed_cnt != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_fit_mode(input logic worst);
    cfg_we    <= 1'b1;
    cfg_wdata <= worst;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly adds of random ids and kills of ids handed out earlier, with some noise.
  task automatic send_random_item();
    int roll;
    int id;
    int idx;
    int pages;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      id = $urandom_range(1, 255);
      pages = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      live_ids.push_back(id);
      send_cmd(CMD_ADD, id, pages);
    end else if (roll < 85) begin
      if (live_ids.size() != 0) begin
        idx = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[idx];
        live_ids.delete(idx);
      end else begin
        id = $urandom_range(1, 255);
      end
      send_cmd(CMD_KILL, id, $urandom_range(0, 63));
    end else if (roll < 92) begin
      send_cmd(CMD_FRAG, $urandom_range(0, 255), $urandom_range(0, 63));
    end else begin
      case ($urandom_range(0, 4))
        0: send_cmd(CMD_ADD, 0, $urandom_range(1, 32));
        1: begin
          id = (live_ids.size() != 0) ? live_ids[$urandom_range(0, live_ids.size() - 1)] : 255;
          send_cmd(CMD_ADD, id, $urandom_range(1, 4));
        end
        2: send_cmd(CMD_ADD, $urandom_range(1, 255),
                    $urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
        3: send_cmd(CMD_KILL, $urandom_range(0, 255), $urandom_range(0, 63));
        default: send_cmd(CMD_RSVD, $urandom_range(0, 255), $urandom_range(0, 63));
      endcase
    end
  endtask

  initial begin
    cmd_ch.valid     <= 1'b0;
    cmd_ch.cmd       <= CMD_FRAG;
    cmd_ch.prog_id   <= '0;
    cmd_ch.req_pages <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_fit_mode(1'b0);
    send_cmd(CMD_FRAG, 0, 0);
    send_cmd(CMD_ADD, 0, 4);
    send_cmd(CMD_ADD, 1, 0);
    send_cmd(CMD_ADD, 1, 33);
    send_cmd(CMD_ADD, 1, 63);
    send_cmd(CMD_ADD, 255, 32);
    send_cmd(CMD_ADD, 2, 1);
    send_cmd(CMD_ADD, 255, 1);
    send_cmd(CMD_KILL, 255, 0);
    send_cmd(CMD_KILL, 255, 0);
    send_cmd(CMD_KILL, 0, 0);
    send_cmd(CMD_RSVD, 170, 42);
    // Fill the pages, then open holes of six and eight pages.
    send_cmd(CMD_ADD, 1, 4);
    send_cmd(CMD_ADD, 2, 6);
    send_cmd(CMD_ADD, 3, 2);
    send_cmd(CMD_ADD, 4, 8);
    send_cmd(CMD_ADD, 5, 12);
    send_cmd(CMD_KILL, 2, 0);
    send_cmd(CMD_KILL, 4, 0);
    send_cmd(CMD_ADD, 6, 5);
    send_cmd(CMD_FRAG, 85, 21);
    drain_replies();

    write_fit_mode(1'b1);
    send_cmd(CMD_KILL, 6, 0);
    send_cmd(CMD_ADD, 7, 5);
    send_cmd(CMD_ADD, 8, 1);
    drain_replies();
    live_ids = '{1, 3, 5, 7, 8};

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          rcv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          rcv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int m = 0; m < 2; m++) begin
        write_fit_mode(((phase + m) % 2) != 0);
        repeat (100) send_random_item();
        drain_replies();
      end
    end

    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0 && owed_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[page_fit_allocator.f]
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_cell.sv
rtl/pfa_scan.sv
rtl/page_fit_allocator.sv
tb/sv/pfa_outcome_checker.sv
tb/sv/page_fit_allocator_tb.sv
